@@ hw/rtl/ial_pkg.sv @@
// Shared constants, codes and types for the indexed array list engine.
// No dependencies; every other file of the block imports this package.

package ial_pkg;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 10;
	localparam int CNT_W     = 11;
	localparam int OP_W      = 3;
	localparam int STAT_W    = 2;
	localparam int DEPTH_DEF = 1024;

	// Request codes.
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BADIDX = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOVE,
		ST_PUT,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/ial_intf.sv @@
// Valid/ready channel interfaces of the indexed array list engine:
// request, result and capacity register write. Depends on ial_pkg.

interface ial_req_if import ial_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic [IDX_W-1:0]         index;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output op, output index, output value, input ready);
	modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface ial_rsp_if import ial_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] read_value;
	logic                     found;
	logic [CNT_W-1:0]         count;

	modport source (output valid, output status, output read_value, output found,
		output count, input ready);
	modport sink   (input valid, input status, input read_value, input found,
		input count, output ready);
endinterface

interface ial_cfg_if import ial_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

@@ hw/rtl/indexed_array_list_engine.sv @@
// Indexed array list engine: ordered list of signed words in an on-chip store.
// Depends on ial_pkg and the channel interfaces in ial_intf.sv.
//
//   Channel | Dir | Payload                           | Beat when
//   --------+-----+-----------------------------------+-----------------------
//   req     | in  | op, index, value                  | req.valid & req.ready
//   rsp     | out | status, read_value, found, count  | rsp.valid & rsp.ready
//   cfg     | in  | capacity                          | cfg.valid & cfg.ready
//
// A read, overwrite, clear or rejected request goes from its beat to ST_DONE,
// where the result is loaded once the output register is free. Insert and delete
// first shift entries in ST_MOVE (insert then writes its value in ST_PUT), and search
// scans in ST_SCAN; in a shift the store reads one entry and writes one entry per cycle.
// Reset clears the count and capacity; the store itself holds no reset.
// req.ready is high only between requests; a result waiting in the output
// register does not block the next beat, but the one after waits for it.

module indexed_array_list_engine import ial_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ial_req_if.sink   req,
	ial_rsp_if.source rsp,
	ial_cfg_if.sink   cfg
);

	localparam int AW = $clog2(DEPTH);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_q;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  rem_q, rem_d;
	logic [AW-1:0]     rp_q, rp_d;
	logic [AW-1:0]     wp_q, wp_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic              pend_q, pend_d;
	logic [OP_W-1:0]   op_q, op_d;
	logic [DATA_W-1:0] val_q, val_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic              found_q, found_d;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [DATA_W-1:0] out_rdval_q;
	logic              out_found_q;
	logic [CNT_W-1:0]  out_count_q;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [DATA_W-1:0] mem_wd;

	logic              req_acc, load_out;
	logic [CNT_W-1:0]  idx_ext;
	logic              full, ins_ok, idx_ok, moving;

	assign req_acc = req.valid && req.ready;
	assign idx_ext = CNT_W'(req.index);
	assign full    = (count_q >= cap_q) || (32'(count_q) >= 32'(DEPTH));
	assign ins_ok  = (idx_ext <= count_q) && !full;
	assign idx_ok  = idx_ext < count_q;
	// The shift and the scan finish once every read is issued and its word is written back (shift) or compared (scan).
	assign moving  = (rem_q != '0) || pend_q;

	assign cfg.ready = 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					if ((req.op == OP_INSERT && ins_ok) || (req.op == OP_DELETE && idx_ok)) begin
						state_d = ST_MOVE;
					end else if (req.op == OP_SEARCH) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MOVE: begin
				if (!moving) begin
					state_d = (op_q == OP_INSERT) ? ST_PUT : ST_DONE;
				end
			end
			ST_PUT: state_d = ST_DONE;
			ST_SCAN: begin
				if (!moving) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Store accesses and datapath updates.
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		mem_we    = 1'b0;
		mem_wa    = wp_q;
		mem_wd    = rd_q;
		mem_re    = 1'b0;
		mem_ra    = rp_q;
		count_d   = count_q;
		rem_d     = rem_q;
		rp_d      = rp_q;
		wp_d      = wp_q;
		idx_d     = idx_q;
		pend_d    = 1'b0;
		op_d      = op_q;
		val_d     = val_q;
		status_d  = status_q;
		found_d   = found_q;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					op_d     = req.op;
					val_d    = req.value;
					idx_d    = AW'(req.index);
					status_d = STAT_OK;
					found_d  = 1'b0;
					rem_d    = '0;
					unique case (req.op)
						OP_INSERT: begin
							if (idx_ext > count_q) begin
								status_d = STAT_BADIDX;
							end else if (full) begin
								status_d = STAT_FULL;
							end else begin
								// Walk downwards from the top, opening a gap at index.
								rem_d   = count_q - idx_ext;
								rp_d    = AW'(count_q - CNT_W'(1));
								wp_d    = AW'(count_q);
								count_d = count_q + CNT_W'(1);
							end
						end
						OP_DELETE: begin
							if (!idx_ok) begin
								status_d = STAT_BADIDX;
							end else begin
								rem_d   = count_q - idx_ext - CNT_W'(1);
								rp_d    = AW'(req.index) + AW'(1);
								wp_d    = AW'(req.index);
								count_d = count_q - CNT_W'(1);
							end
						end
						OP_READ: begin
							if (!idx_ok) begin
								status_d = STAT_BADIDX;
							end else begin
								mem_re = 1'b1;
								mem_ra = AW'(req.index);
							end
						end
						OP_WRITE: begin
							if (!idx_ok) begin
								status_d = STAT_BADIDX;
							end else begin
								mem_we = 1'b1;
								mem_wa = AW'(req.index);
								mem_wd = req.value;
							end
						end
						OP_SEARCH: begin
							rem_d = count_q;
							rp_d  = '0;
						end
						OP_CLEAR: count_d = '0;
						default: ;
					endcase
				end
			end
			ST_MOVE, ST_SCAN: begin
				if (rem_q != '0) begin
					mem_re = 1'b1;
					rp_d   = (op_q == OP_INSERT) ? rp_q - AW'(1) : rp_q + AW'(1);
					rem_d  = rem_q - CNT_W'(1);
					pend_d = 1'b1;
				end
				// The word read in the previous cycle is now in rd_q.
				if (pend_q) begin
					if (state_q == ST_MOVE) begin
						mem_we = 1'b1;
						wp_d   = (op_q == OP_INSERT) ? wp_q - AW'(1) : wp_q + AW'(1);
					end else if (rd_q == val_q) begin
						found_d = 1'b1;
					end
				end
			end
			ST_PUT: begin
				mem_we = 1'b1;
				mem_wa = idx_q;
				mem_wd = val_q;
			end
			ST_DONE: load_out = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cap_q       <= '0;
			rem_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			pend_q  <= pend_d;
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.capacity;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rp_q     <= rp_d;
		wp_q     <= wp_d;
		idx_q    <= idx_d;
		op_q     <= op_d;
		val_q    <= val_d;
		status_q <= status_d;
		found_q  <= found_d;
		if (load_out) begin
			out_status_q <= status_q;
			out_rdval_q  <= (op_q == OP_READ && status_q == STAT_OK) ? rd_q : '0;
			out_found_q  <= found_q;
			out_count_q  <= count_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_rdval_q;
	assign rsp.found      = out_found_q;
	assign rsp.count      = out_count_q;

	// The shift streams reads ahead of writes and must never touch one entry twice in a cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_wa != mem_ra))
		else $error("store read and write collide on one address");

	// The count moves only as the result of a request beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(req.valid && req.ready) |=> $stable(count_q))
		else $error("count changed without a request beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(DEPTH))
		else $error("count exceeds the store depth");

endmodule

@@ sim/indexed_array_list_engine_test.sv @@
// Self-checking testbench for indexed_array_list_engine: directed and random list requests
// are checked against an in-bench list predictor, under several idle and stall patterns.
// Depends on ial_pkg and the channel interfaces in ial_intf.sv.

module indexed_array_list_engine_test import ial_pkg::*; ();

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int DRAIN_SLACK = 8;
	localparam int HOLD_CYCLES = 300;

	// Codes the block treats as no operation.
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	typedef struct {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] read_value;
		logic                     found;
		logic [CNT_W-1:0]         count;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	ial_req_if req_ch ();
	ial_rsp_if rsp_ch ();
	ial_cfg_if cfg_ch ();

	indexed_array_list_engine #(.DEPTH(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predicted contents of the list and the capacity register.
	logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
	int                       list_len;
	logic [CNT_W-1:0]         cap_reg;

	list_result_t pending_results [$];
	int           err_count;
	int           idle_pct;
	int           stall_pct;
	int           hold_left;

	function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] val);
		list_result_t r;
		int cap_eff;
		int i;
		r.status     = STAT_OK;
		r.read_value = '0;
		r.found      = 1'b0;
		cap_eff = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
		case (op)
			OP_INSERT: begin
				// The index check takes precedence over the full check.
				if (int'(idx) > list_len) begin
					r.status = STAT_BADIDX;
				end else if (list_len >= cap_eff) begin
					r.status = STAT_FULL;
				end else begin
					for (i = list_len; i > int'(idx); i--)
						list_mem[i] = list_mem[i-1];
					list_mem[idx] = val;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (int'(idx) >= list_len) begin
					r.status = STAT_BADIDX;
				end else begin
					for (i = int'(idx); i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			OP_READ: begin
				if (int'(idx) >= list_len)
					r.status = STAT_BADIDX;
				else
					r.read_value = list_mem[idx];
			end
			OP_WRITE: begin
				if (int'(idx) >= list_len)
					r.status = STAT_BADIDX;
				else
					list_mem[idx] = val;
			end
			OP_SEARCH: begin
				for (i = 0; i < list_len; i++) begin
					if (list_mem[i] == val)
						r.found = 1'b1;
				end
			end
			OP_CLEAR: begin
				list_len = 0;
			end
			default: ;
		endcase
		r.count = CNT_W'(list_len);
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] word_pool [8];
		word_pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1, 32'sh1,
			32'sh5555_5555, 32'shAAAA_AAAA, 32'sh2A};
		if ($urandom_range(1) == 0)
			return word_pool[$urandom_range(7)];
		return $urandom();
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] exp_v,
			input logic signed [63:0] act_v);
		if (exp_v !== act_v) begin
			err_count++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	// The request beat is predicted at the edge that accepts it.
	task automatic send_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] val);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.index <= idx;
		req_ch.value <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(list_apply(op, idx, val));
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic cap_write(input logic [CNT_W-1:0] cap);
		@(negedge clk);
		cfg_ch.valid    <= 1'b1;
		cfg_ch.capacity <= cap;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cap_reg = cap;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly well-formed requests on the live list, with some bad indexes and spare codes.
	task automatic random_item(output logic [OP_W-1:0] op, output logic [IDX_W-1:0] idx,
			output logic signed [DATA_W-1:0] val);
		int pick;
		int top;
		pick = $urandom_range(99);
		idx  = IDX_W'($urandom());
		val  = pick_value();
		top  = (list_len > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : list_len;
		if (pick < 32) begin
			op  = OP_INSERT;
			idx = IDX_W'($urandom_range(top));
		end else if (pick < 72) begin
			op = (pick < 48) ? OP_DELETE : (pick < 62) ? OP_READ : OP_WRITE;
			if (list_len > 0)
				idx = IDX_W'($urandom_range(list_len - 1));
		end else if (pick < 86) begin
			op = OP_SEARCH;
			if (list_len > 0 && $urandom_range(9) < 6)
				val = list_mem[$urandom_range(list_len - 1)];
		end else if (pick < 89) begin
			op = OP_CLEAR;
		end else if (pick < 96) begin
			case ($urandom_range(3))
				0: op = OP_INSERT;
				1: op = OP_DELETE;
				2: op = OP_READ;
				default: op = OP_WRITE;
			endcase
			if (top < LIST_DEPTH - 1)
				idx = IDX_W'($urandom_range(LIST_DEPTH - 1, top + 1));
		end else begin
			op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
		end
	endtask

	task automatic run_phase(input int n, input logic [CNT_W-1:0] cap, input int idle,
			input int stall);
		logic [OP_W-1:0] op;
		logic [IDX_W-1:0] idx;
		logic signed [DATA_W-1:0] val;
		drain();
		cap_write(cap);
		idle_pct  = idle;
		stall_pct = stall;
		repeat (n) begin
			random_item(op, idx, val);
			send_req(op, idx, val);
		end
	endtask

	task automatic test_directed_ops();
		// Capacity is zero after reset, so every insert is refused as full.
		send_req(OP_INSERT, 10'd0, 32'sd5);
		send_req(OP_READ, 10'd0, 32'sd0);
		send_req(OP_SEARCH, 10'd0, 32'sd0);
		send_req(OP_SPARE_6, 10'd3, 32'sd1);
		send_req(OP_SPARE_7, 10'd1023, -32'sd1);
		drain();
		cap_write(11'd4);
		send_req(OP_INSERT, 10'd1, 32'sd9);
		send_req(OP_INSERT, 10'd0, 32'sh8000_0000);
		send_req(OP_INSERT, 10'd0, 32'sh7FFF_FFFF);
		send_req(OP_INSERT, 10'd2, -32'sd1);
		send_req(OP_INSERT, 10'd1, 32'sd0);
		send_req(OP_INSERT, 10'd4, 32'sd77);
		send_req(OP_READ, 10'd3, 32'sd0);
		send_req(OP_WRITE, 10'd1023, 32'sd3);
		send_req(OP_DELETE, 10'd1023, 32'sd0);
		send_req(OP_SEARCH, 10'd0, 32'sh8000_0000);
		send_req(OP_DELETE, 10'd0, 32'sd0);
		send_req(OP_CLEAR, 10'd512, 32'sd0);
	endtask

	task automatic test_capacity_shrink();
		drain();
		cap_write(11'd8);
		repeat (6) send_req(OP_INSERT, IDX_W'($urandom_range(list_len)), pick_value());
		drain();
		// Lowering the capacity below the count keeps the entries; inserts at a valid index report full.
		cap_write(11'd3);
		send_req(OP_INSERT, 10'd0, 32'sd1);
		send_req(OP_INSERT, IDX_W'(list_len + 1), 32'sd1);
		send_req(OP_READ, 10'd5, 32'sd0);
		send_req(OP_WRITE, 10'd4, 32'sd123);
		send_req(OP_DELETE, 10'd0, 32'sd0);
		send_req(OP_SEARCH, 10'd0, 32'sd123);
		drain();
		cap_write(11'd2047);
		send_req(OP_INSERT, IDX_W'(list_len), -32'sd7);
	endtask

	task automatic test_random_traffic();
		run_phase(100, 11'd16, 0, 0);
		run_phase(90, 11'd32, 79, 0);
		run_phase(90, 11'd24, 0, 79);
		run_phase(90, 11'd40, 31, 31);
	endtask

	task automatic test_capacity_extremes();
		run_phase(30, 11'd1, 0, 31);
		run_phase(20, 11'd0, 31, 0);
		run_phase(60, 11'd1024, 0, 0);
		run_phase(80, 11'd2047, 31, 31);
	endtask

	task automatic test_backpressure();
		logic [OP_W-1:0] op;
		logic [IDX_W-1:0] idx;
		logic signed [DATA_W-1:0] val;
		drain();
		cap_write(11'd12);
		idle_pct  = 0;
		stall_pct = 0;
		// The result side holds off while requests keep coming, so the input stalls.
		hold_left = HOLD_CYCLES;
		repeat (10) begin
			random_item(op, idx, val);
			send_req(op, idx, val);
		end
		// Pause the request side until every outstanding result is back.
		drain();
		repeat (10) begin
			random_item(op, idx, val);
			send_req(op, idx, val);
		end
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		list_result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result beat: expected none, got status %0d count %0d",
					$time, rsp_ch.status, rsp_ch.count);
			end else begin
				exp_r = pending_results.pop_front();
				check_field("status", 64'(exp_r.status), 64'(rsp_ch.status));
				check_field("read_value", 64'(exp_r.read_value), 64'(rsp_ch.read_value));
				check_field("found", 64'(exp_r.found), 64'(rsp_ch.found));
				check_field("count", 64'(exp_r.count), 64'(rsp_ch.count));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		req_ch.valid    = 1'b0;
		req_ch.op       = OP_INSERT;
		req_ch.index    = '0;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.capacity = '0;
		list_len  = 0;
		cap_reg   = '0;
		err_count = 0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		test_capacity_shrink();
		test_random_traffic();
		test_backpressure();
		test_capacity_extremes();

		drain();
		repeat (32) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
